// ===== hw/rtl/script_source_tokenizer_top_macros.svh =====
// Assertion helpers for the tokenizer
`ifndef SCRIPT_SOURCE_TOKENIZER_TOP_MACROS_SVH
`define SCRIPT_SOURCE_TOKENIZER_TOP_MACROS_SVH

// Implication checked on every clock edge outside reset
`define SST_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication checked outside reset
`define SST_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/sst_pkg.sv =====
// ----------------------------------------------------------------------------
// sst_pkg
// Shared types, kind and mode codes, and character helpers for the tokenizer.
// ----------------------------------------------------------------------------
`default_nettype none
package sst_pkg;

  localparam int OFFSET_BITS_DEF = 16;
  localparam int LINE_BITS_DEF   = 16;
  localparam int FW              = 16;  // width of offset, length, line fields

  typedef enum logic [5:0] {
    K_EOL, K_SPACE, K_COMMENT, K_ADD_ASSIGN, K_INC, K_ADD, K_ARROW,
    K_SUB_ASSIGN, K_DEC, K_SUB, K_MUL_ASSIGN, K_MUL, K_DIV_ASSIGN, K_DIV,
    K_MOD_ASSIGN, K_MOD, K_GE, K_SHR_ASSIGN, K_SHR, K_GT, K_LE,
    K_SHL_ASSIGN, K_SHL, K_LT, K_EQUAL, K_ASSIGN, K_NOT_EQUAL, K_NOT,
    K_LOGIC_AND, K_AND_ASSIGN, K_AND, K_LOGIC_OR, K_OR_ASSIGN, K_OR,
    K_NOT_ASSIGN, K_XOR_ASSIGN, K_XOR, K_LPAREN, K_RPAREN, K_LBRACK,
    K_RBRACK, K_LBRACE, K_RBRACE, K_DOT, K_COLON, K_SEMICOLON, K_COMMA,
    K_STRING, K_CHAR, K_LONG, K_DOUBLE, K_IDENT, K_UNKNOWN
  } kind_t;

  typedef enum logic [4:0] {
    M_IDLE, M_CR, M_BLANK, M_PLUS, M_MINUS, M_STAR, M_SLASH, M_PERCENT,
    M_GT, M_GTGT, M_LT, M_LTLT, M_EQ, M_BANG, M_AMP, M_PIPE, M_TILDE,
    M_CARET, M_LCOMMENT, M_BCOMMENT, M_STRING, M_NZERO, M_NBIN, M_NHEX,
    M_NDEC, M_IDENT
  } mode_t;

  // scan flag bits
  localparam int FB_MARK   = 0;
  localparam int FB_DOT    = 1;
  localparam int FB_SQUOTE = 2;

  // one token as carried between the stages
  typedef struct packed {
    logic [5:0]    kind;
    logic [FW-1:0] start;
    logic [FW-1:0] len;
    logic [FW-1:0] line;
  } tok_t;

  // result of one byte: up to two tokens
  typedef struct packed {
    logic  n0;      // first token present
    logic  n1;      // second token present
    logic  eos;
    tok_t  t0;
    tok_t  t1;
  } step_t;

  function automatic logic is_digit(input logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7a) || (c >= 8'h41 && c <= 8'h5a) || c == 8'h5f;
  endfunction

  function automatic logic is_hex(input logic [7:0] c);
    return is_digit(c) || (c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46);
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/sst_scan.sv =====
// ----------------------------------------------------------------------------
// sst_scan
// Scanner state and per-byte token logic; presents up to two tokens per byte.
// ----------------------------------------------------------------------------
`default_nettype none
module sst_scan #(
  parameter int OFFSET_BITS = sst_pkg::OFFSET_BITS_DEF,
  parameter int LINE_BITS   = sst_pkg::LINE_BITS_DEF
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    step_en,
  input  wire logic [7:0]              c,
  input  wire logic                    eos,
  input  wire logic                    cfg_we,
  input  wire logic [sst_pkg::FW-1:0]  cfg_data,
  output sst_pkg::step_t               step_o
);

  localparam logic [OFFSET_BITS-1:0] OFF_MAX = '1;
  localparam logic [LINE_BITS-1:0]   LN_MAX  = '1;
  localparam int FW = sst_pkg::FW;

  sst_pkg::mode_t          mode_r, mode_nxt;
  logic [2:0]              flags_r, flags_nxt;
  logic [OFFSET_BITS-1:0]  tstart_r, tstart_nxt;
  logic [OFFSET_BITS-1:0]  off_r, off_nxt;
  logic [LINE_BITS-1:0]    line_r, line_nxt;
  logic [LINE_BITS-1:0]    tline_r, tline_nxt;
  logic [FW-1:0]           first_r;
  logic                    fresh_r;
  sst_pkg::step_t          st;

  function automatic logic [LINE_BITS-1:0] sat_line(input logic [FW-1:0] v);
    if (32'(v) > 32'(LN_MAX)) return LN_MAX;
    return LINE_BITS'(v);
  endfunction

  logic [LINE_BITS-1:0] first_sat;
  assign first_sat = sat_line(first_r);

  function automatic logic [FW-1:0] sat16(input logic [OFFSET_BITS:0] v);
    if (64'(v) > 64'hFFFF) return '1;
    return FW'(v);
  endfunction

  // token built from start and exclusive end
  function automatic sst_pkg::tok_t mk(input logic [5:0] k,
      input logic [OFFSET_BITS-1:0] s, input logic [OFFSET_BITS:0] e,
      input logic [LINE_BITS-1:0] ln);
    sst_pkg::tok_t t;
    logic [OFFSET_BITS:0] d;
    d = e - {1'b0, s};
    t.kind  = k;
    t.start = FW'(s);
    t.line  = FW'(ln);
    if (e > {1'b0, s}) t.len = sat16(d);
    else t.len = FW'(1);
    return t;
  endfunction

  function automatic logic [5:0] pend_kind(input sst_pkg::mode_t m, input logic [2:0] f);
    unique case (m)
      sst_pkg::M_BLANK:   return sst_pkg::K_SPACE;
      sst_pkg::M_PLUS:    return sst_pkg::K_ADD;
      sst_pkg::M_MINUS:   return sst_pkg::K_SUB;
      sst_pkg::M_STAR:    return sst_pkg::K_MUL;
      sst_pkg::M_SLASH:   return sst_pkg::K_DIV;
      sst_pkg::M_PERCENT: return sst_pkg::K_MOD;
      sst_pkg::M_GT:      return sst_pkg::K_GT;
      sst_pkg::M_GTGT:    return sst_pkg::K_SHR;
      sst_pkg::M_LT:      return sst_pkg::K_LT;
      sst_pkg::M_LTLT:    return sst_pkg::K_SHL;
      sst_pkg::M_EQ:      return sst_pkg::K_ASSIGN;
      sst_pkg::M_BANG, sst_pkg::M_TILDE: return sst_pkg::K_NOT;
      sst_pkg::M_AMP:     return sst_pkg::K_AND;
      sst_pkg::M_PIPE:    return sst_pkg::K_OR;
      sst_pkg::M_CARET:   return sst_pkg::K_XOR;
      sst_pkg::M_LCOMMENT, sst_pkg::M_BCOMMENT: return sst_pkg::K_COMMENT;
      sst_pkg::M_STRING:
        return f[sst_pkg::FB_SQUOTE] ? sst_pkg::K_CHAR : sst_pkg::K_STRING;
      sst_pkg::M_NZERO, sst_pkg::M_NBIN, sst_pkg::M_NHEX: return sst_pkg::K_LONG;
      sst_pkg::M_NDEC:
        return f[sst_pkg::FB_DOT] ? sst_pkg::K_DOUBLE : sst_pkg::K_LONG;
      sst_pkg::M_IDENT:   return sst_pkg::K_IDENT;
      default:            return sst_pkg::K_UNKNOWN;
    endcase
  endfunction

  // operator follow: valid flag, complete kind, or mode change
  logic                    of_done, of_chg;
  logic [5:0]              of_kind;
  sst_pkg::mode_t          of_mode;
  always_comb begin
    of_done = 1'b0;
    of_chg  = 1'b0;
    of_kind = sst_pkg::K_UNKNOWN;
    of_mode = mode_r;
    case (mode_r)
      sst_pkg::M_PLUS: begin
        if (c == "=") begin of_done = 1'b1; of_kind = sst_pkg::K_ADD_ASSIGN; end
        else if (c == "+") begin of_done = 1'b1; of_kind = sst_pkg::K_INC; end
      end
      sst_pkg::M_MINUS: begin
        if (c == ">") begin of_done = 1'b1; of_kind = sst_pkg::K_ARROW; end
        else if (c == "=") begin of_done = 1'b1; of_kind = sst_pkg::K_SUB_ASSIGN; end
        else if (c == "-") begin of_done = 1'b1; of_kind = sst_pkg::K_DEC; end
      end
      sst_pkg::M_STAR:
        if (c == "=") begin of_done = 1'b1; of_kind = sst_pkg::K_MUL_ASSIGN; end
      sst_pkg::M_SLASH: begin
        if (c == "/") begin of_chg = 1'b1; of_mode = sst_pkg::M_LCOMMENT; end
        else if (c == "*") begin of_chg = 1'b1; of_mode = sst_pkg::M_BCOMMENT; end
        else if (c == "=") begin of_done = 1'b1; of_kind = sst_pkg::K_DIV_ASSIGN; end
      end
      sst_pkg::M_PERCENT:
        if (c == "=") begin of_done = 1'b1; of_kind = sst_pkg::K_MOD_ASSIGN; end
      sst_pkg::M_GT: begin
        if (c == "=") begin of_done = 1'b1; of_kind = sst_pkg::K_GE; end
        else if (c == ">") begin of_chg = 1'b1; of_mode = sst_pkg::M_GTGT; end
      end
      sst_pkg::M_GTGT:
        if (c == "=") begin of_done = 1'b1; of_kind = sst_pkg::K_SHR_ASSIGN; end
      sst_pkg::M_LT: begin
        if (c == "=") begin of_done = 1'b1; of_kind = sst_pkg::K_LE; end
        else if (c == "<") begin of_chg = 1'b1; of_mode = sst_pkg::M_LTLT; end
      end
      sst_pkg::M_LTLT:
        if (c == "=") begin of_done = 1'b1; of_kind = sst_pkg::K_SHL_ASSIGN; end
      sst_pkg::M_EQ:
        if (c == "=") begin of_done = 1'b1; of_kind = sst_pkg::K_EQUAL; end
      sst_pkg::M_BANG:
        if (c == "=") begin of_done = 1'b1; of_kind = sst_pkg::K_NOT_EQUAL; end
      sst_pkg::M_AMP: begin
        if (c == "&") begin of_done = 1'b1; of_kind = sst_pkg::K_LOGIC_AND; end
        else if (c == "=") begin of_done = 1'b1; of_kind = sst_pkg::K_AND_ASSIGN; end
      end
      sst_pkg::M_PIPE: begin
        if (c == "|") begin of_done = 1'b1; of_kind = sst_pkg::K_LOGIC_OR; end
        else if (c == "=") begin of_done = 1'b1; of_kind = sst_pkg::K_OR_ASSIGN; end
      end
      sst_pkg::M_TILDE:
        if (c == "=") begin of_done = 1'b1; of_kind = sst_pkg::K_NOT_ASSIGN; end
      sst_pkg::M_CARET:
        if (c == "=") begin of_done = 1'b1; of_kind = sst_pkg::K_XOR_ASSIGN; end
      default: ;
    endcase
  end

  // start of a new token at the current byte
  logic                    b_single, b_eol;
  logic [5:0]              b_kind;
  sst_pkg::mode_t          b_mode;
  logic                    b_sq;
  always_comb begin
    b_single = 1'b0;
    b_eol    = 1'b0;
    b_kind   = sst_pkg::K_UNKNOWN;
    b_mode   = sst_pkg::M_IDLE;
    b_sq     = 1'b0;
    case (c)
      8'h0d: b_mode = sst_pkg::M_CR;
      8'h0a: begin b_single = 1'b1; b_eol = 1'b1; b_kind = sst_pkg::K_EOL; end
      8'h20, 8'h09: b_mode = sst_pkg::M_BLANK;
      "+": b_mode = sst_pkg::M_PLUS;
      "-": b_mode = sst_pkg::M_MINUS;
      "*": b_mode = sst_pkg::M_STAR;
      "/": b_mode = sst_pkg::M_SLASH;
      "%": b_mode = sst_pkg::M_PERCENT;
      ">": b_mode = sst_pkg::M_GT;
      "<": b_mode = sst_pkg::M_LT;
      "=": b_mode = sst_pkg::M_EQ;
      "!": b_mode = sst_pkg::M_BANG;
      "&": b_mode = sst_pkg::M_AMP;
      "|": b_mode = sst_pkg::M_PIPE;
      "~": b_mode = sst_pkg::M_TILDE;
      "^": b_mode = sst_pkg::M_CARET;
      "(": begin b_single = 1'b1; b_kind = sst_pkg::K_LPAREN; end
      ")": begin b_single = 1'b1; b_kind = sst_pkg::K_RPAREN; end
      "[": begin b_single = 1'b1; b_kind = sst_pkg::K_LBRACK; end
      "]": begin b_single = 1'b1; b_kind = sst_pkg::K_RBRACK; end
      "{": begin b_single = 1'b1; b_kind = sst_pkg::K_LBRACE; end
      "}": begin b_single = 1'b1; b_kind = sst_pkg::K_RBRACE; end
      ".": begin b_single = 1'b1; b_kind = sst_pkg::K_DOT; end
      ":": begin b_single = 1'b1; b_kind = sst_pkg::K_COLON; end
      ";": begin b_single = 1'b1; b_kind = sst_pkg::K_SEMICOLON; end
      ",": begin b_single = 1'b1; b_kind = sst_pkg::K_COMMA; end
      8'h22: b_mode = sst_pkg::M_STRING;
      8'h27: begin b_mode = sst_pkg::M_STRING; b_sq = 1'b1; end
      "0": b_mode = sst_pkg::M_NZERO;
      default: begin
        if (sst_pkg::is_digit(c)) b_mode = sst_pkg::M_NDEC;
        else if (sst_pkg::is_alpha(c)) b_mode = sst_pkg::M_IDENT;
        else b_single = 1'b1;
      end
    endcase
  end

  logic [OFFSET_BITS:0]    pos1;
  logic [LINE_BITS-1:0]    line_inc;
  assign pos1     = {1'b0, off_r} + 1'b1;
  assign line_inc = (line_r == LN_MAX) ? line_r : line_r + 1'b1;

  // main per-byte update
  always_comb begin
    logic                   do_begin, end_prev, eol_tok;
    logic [OFFSET_BITS-1:0] crpos;
    sst_pkg::mode_t         m;
    logic [2:0]             f;
    logic [OFFSET_BITS-1:0] ts;
    logic [LINE_BITS-1:0]   tl, ln;
    sst_pkg::tok_t          tk;
    logic                   has;
    do_begin = 1'b0;
    end_prev = 1'b0;
    eol_tok  = 1'b0;
    tk       = '0;
    has      = 1'b0;
    crpos    = (off_r != '0) ? off_r - 1'b1 : '0;
    m   = mode_r;
    f   = flags_r;
    ts  = tstart_r;
    tl  = tline_r;
    ln  = line_r;
    st  = '0;
    st.eos = eos;
    st.t0  = '0;
    st.t1  = '0;
    case (mode_r)
      sst_pkg::M_IDLE: do_begin = 1'b1;
      sst_pkg::M_CR:
        if (c == 8'h0a) eol_tok = 1'b1;
        else end_prev = 1'b1;
      sst_pkg::M_BLANK:
        if (c != 8'h20 && c != 8'h09) end_prev = 1'b1;
      sst_pkg::M_LCOMMENT: begin
        if (flags_r[sst_pkg::FB_MARK] && c == 8'h0a) begin
          // CR LF closes the comment: comment, then EOL from the CR
          st.n0 = 1'b1;
          st.t0 = mk(sst_pkg::K_COMMENT, tstart_r, {1'b0, crpos}, tline_r);
          st.n1 = 1'b1;
          st.t1 = mk(sst_pkg::K_EOL, crpos, pos1, line_r);
          m = sst_pkg::M_IDLE;
          f = '0;
          ts = crpos;
          tl = line_r;
          ln = line_inc;
        end else begin
          f[sst_pkg::FB_MARK] = (c == 8'h0d);
          if (c == 8'h0a) end_prev = 1'b1;
        end
      end
      sst_pkg::M_BCOMMENT: begin
        if (flags_r[sst_pkg::FB_MARK] && c == "/") begin
          st.n0 = 1'b1;
          st.t0 = mk(sst_pkg::K_COMMENT, tstart_r, pos1, tline_r);
          m = sst_pkg::M_IDLE;
          f = '0;
        end else begin
          f[sst_pkg::FB_MARK] = (c == "*");
          if (c == 8'h0a) ln = line_inc;
        end
      end
      sst_pkg::M_STRING: begin
        if (flags_r[sst_pkg::FB_MARK]) f[sst_pkg::FB_MARK] = 1'b0;
        else if (c == 8'h5c) f[sst_pkg::FB_MARK] = 1'b1;
        else if (c == (flags_r[sst_pkg::FB_SQUOTE] ? 8'h27 : 8'h22)) begin
          st.n0 = 1'b1;
          st.t0 = mk(pend_kind(mode_r, flags_r), tstart_r, pos1, tline_r);
          m = sst_pkg::M_IDLE;
          f = '0;
        end
      end
      sst_pkg::M_NZERO: begin
        if (c == "b" || c == "B") m = sst_pkg::M_NBIN;
        else if (c == "x" || c == "X") m = sst_pkg::M_NHEX;
        else begin
          m = sst_pkg::M_NDEC;
          f = '0;
          if (c == ".") f[sst_pkg::FB_DOT] = 1'b1;
          else if (!sst_pkg::is_digit(c)) end_prev = 1'b1;
        end
      end
      sst_pkg::M_NBIN:
        if (c != "0" && c != "1") end_prev = 1'b1;
      sst_pkg::M_NHEX:
        if (!sst_pkg::is_hex(c)) end_prev = 1'b1;
      sst_pkg::M_NDEC: begin
        if (sst_pkg::is_digit(c)) ;
        else if (c == "." && !flags_r[sst_pkg::FB_DOT]) f[sst_pkg::FB_DOT] = 1'b1;
        else end_prev = 1'b1;
      end
      sst_pkg::M_IDENT:
        if (!sst_pkg::is_alpha(c) && !sst_pkg::is_digit(c)) end_prev = 1'b1;
      default: begin
        if (of_done) begin
          st.n0 = 1'b1;
          st.t0 = mk(of_kind, tstart_r, pos1, tline_r);
          m = sst_pkg::M_IDLE;
          f = '0;
        end else if (of_chg) begin
          m = of_mode;
          if (of_mode == sst_pkg::M_LCOMMENT || of_mode == sst_pkg::M_BCOMMENT) f = '0;
        end else end_prev = 1'b1;
      end
    endcase

    if (eol_tok) begin
      st.n0 = 1'b1;
      st.t0 = mk(sst_pkg::K_EOL, tstart_r, pos1, tline_r);
      m = sst_pkg::M_IDLE;
      f = '0;
      ln = line_inc;
    end

    if (end_prev) begin
      // note NZERO case: pending kind uses the flags just computed
      st.n0 = 1'b1;
      st.t0 = mk(pend_kind(m, f), tstart_r, {1'b0, off_r}, tline_r);
      do_begin = 1'b1;
    end

    if (do_begin) begin
      ts = off_r;
      tl = line_r;
      f  = '0;
      f[sst_pkg::FB_SQUOTE] = b_sq;
      m  = b_mode;
      if (b_single) begin
        tk = mk(b_kind, off_r, pos1, line_r);
        if (end_prev) begin st.n1 = 1'b1; st.t1 = tk; end
        else begin st.n0 = 1'b1; st.t0 = tk; end
        m = sst_pkg::M_IDLE;
        f = '0;
        if (b_eol) ln = line_inc;
      end
    end

    if (eos) begin
      has = st.n0;
      if (m != sst_pkg::M_IDLE) begin
        tk = mk(pend_kind(m, f), ts, pos1, tl);
        if (has) begin st.n1 = 1'b1; st.t1 = tk; end
        else begin st.n0 = 1'b1; st.t0 = tk; end
      end
      mode_nxt   = sst_pkg::M_IDLE;
      flags_nxt  = '0;
      tstart_nxt = '0;
      tline_nxt  = '0;
      off_nxt    = '0;
      line_nxt   = first_sat;
    end else begin
      mode_nxt   = m;
      flags_nxt  = f;
      tstart_nxt = ts;
      tline_nxt  = tl;
      off_nxt    = (off_r == OFF_MAX) ? off_r : pos1[OFFSET_BITS-1:0];
      line_nxt   = ln;
    end
  end

  // tokens of the byte on the input go straight to the result register
  assign step_o = st;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= sst_pkg::M_IDLE;
      flags_r  <= '0;
      tstart_r <= '0;
      tline_r  <= '0;
      off_r    <= '0;
      line_r   <= '0;
      first_r  <= '0;
      fresh_r  <= 1'b1;
    end else begin
      if (step_en) begin
        mode_r   <= mode_nxt;
        flags_r  <= flags_nxt;
        tstart_r <= tstart_nxt;
        tline_r  <= tline_nxt;
        off_r    <= off_nxt;
        line_r   <= line_nxt;
        fresh_r  <= eos;
      end else if (cfg_we) begin
        first_r <= cfg_data;
        if (fresh_r) line_r <= sat_line(cfg_data);
      end
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/sst_outq.sv =====
// ----------------------------------------------------------------------------
// sst_outq
// Holds one byte's tokens and delivers them one word at a time.
// ----------------------------------------------------------------------------
`default_nettype none
module sst_outq (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            load,
  input  sst_pkg::step_t       step_i,
  input  wire logic            out_ready,
  output logic                 busy,
  output logic                 out_valid,
  output sst_pkg::tok_t        tok_o,
  output logic                 last_o,
  output logic                 eos_o
);

  logic [1:0]     cnt_r;
  sst_pkg::tok_t  t1_r;
  logic           eos_r;

  assign out_valid = cnt_r != 2'd0;
  assign last_o    = cnt_r == 2'd1;
  assign eos_o     = last_o & eos_r;

  // a pending word may leave in the same cycle a new byte loads
  assign busy = (cnt_r == 2'd2) || (cnt_r == 2'd1 && !out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
      eos_r <= 1'b0;
    end else if (load) begin
      cnt_r <= {1'b0, step_i.n0} + {1'b0, step_i.n1};
      eos_r <= step_i.eos;
      tok_o <= step_i.t0;
      t1_r  <= step_i.t1;
    end else if (out_valid && out_ready) begin
      cnt_r <= cnt_r - 2'd1;
      tok_o <= t1_r;
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/script_source_tokenizer_top.sv =====
// ----------------------------------------------------------------------------
// script_source_tokenizer_top
// Streaming source tokenizer: one byte in, up to two tokens out.
// ----------------------------------------------------------------------------
// channel | dir | handshake          | words
// in_     | in  | in_valid/in_ready  | byte_value, end_of_source
// out_    | out | out_valid/out_ready| kind, start, length, line, run_end, done
// cfg_    | in  | cfg_valid/cfg_ready| first_line
//
// One byte per cycle while in_ready is high; tokens appear in the cycle after their byte.
// A byte that yields two tokens holds off the next byte until its first token has left.
// Output stall backs up into in_ready; rst_n is synchronous.
// Config writes are taken in any cycle no byte is accepted.
`default_nettype none
`include "script_source_tokenizer_top_macros.svh"
module script_source_tokenizer_top #(
  parameter int OFFSET_BITS = sst_pkg::OFFSET_BITS_DEF,
  parameter int LINE_BITS   = sst_pkg::LINE_BITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_byte_value,
  input  wire logic        in_end_of_source,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [5:0]       out_token_kind,
  output logic [15:0]      out_start_offset,
  output logic [15:0]      out_token_length,
  output logic [15:0]      out_line_number,
  output logic             out_run_end,
  output logic             out_source_done,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [15:0] cfg_first_line
);

  logic           busy, load;
  sst_pkg::step_t step;
  sst_pkg::tok_t  tok;

  assign in_ready  = !busy;
  assign load      = in_valid && in_ready;
  assign cfg_ready = !load;

  sst_scan #(.OFFSET_BITS(OFFSET_BITS), .LINE_BITS(LINE_BITS)) u_scan (
    .clk, .rst_n, .step_en(load), .c(in_byte_value), .eos(in_end_of_source),
    .cfg_we(cfg_valid && cfg_ready), .cfg_data(cfg_first_line), .step_o(step)
  );

  sst_outq u_outq (
    .clk, .rst_n, .load, .step_i(step), .out_ready, .busy,
    .out_valid, .tok_o(tok), .last_o(out_run_end), .eos_o(out_source_done)
  );

  assign out_token_kind   = tok.kind;
  assign out_start_offset = tok.start;
  assign out_token_length = tok.len;
  assign out_line_number  = tok.line;

  `SST_ASSERT_IMP(a_len_nonzero, out_valid, out_token_length != 16'd0, "zero token length")
  `SST_ASSERT_IMP(a_done_last, out_valid && out_source_done, out_run_end, "done without run end")
  `SST_ASSERT_IMP(a_kind_range, out_valid, out_token_kind <= 6'd52, "kind out of range")
  `SST_ASSERT_NXT(a_stall_hold, out_valid && !out_ready, out_valid, "result dropped")

endmodule
`default_nettype wire
